@@ hw/rtl/armm_pkg.sv @@
// Shared types and constants for the audio route matrix mixer.
`default_nettype none

package armm_pkg;

   localparam int MAX_ROUTES_DEF = 16;
   localparam int NUM_CH_DEF     = 4;

   localparam int CH_W      = 4;
   localparam int SMP_W     = 16;
   localparam int PROD_W    = 2 * SMP_W;
   localparam int FRAC_W    = 12;
   localparam int OUT_CH    = 4;
   localparam int HELD_W    = 5;
   localparam int CFG_W     = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CMP_W     = CH_W + 1;

   localparam logic [CFG_W-1:0]         ACT_RESET = 3'd4;
   localparam logic [CSR_IDX_W-1:0]     CSR_ACTIVE_INPUTS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0]     CSR_ACTIVE_OUTPUTS = 1'd1;
   localparam logic signed [SMP_W-1:0]  SMP_MAX = 16'sh7FFF;
   localparam logic signed [SMP_W-1:0]  SMP_MIN = 16'sh8000;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_MIX    = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic [CH_W-1:0]          src_channel;
      logic [CH_W-1:0]          dst_channel;
      logic signed [SMP_W-1:0]  route_gain;
      logic signed [SMP_W-1:0]  in_sample_0;
      logic signed [SMP_W-1:0]  in_sample_1;
      logic signed [SMP_W-1:0]  in_sample_2;
      logic signed [SMP_W-1:0]  in_sample_3;
   } req_word_type;

   typedef struct packed {
      logic signed [SMP_W-1:0]  out_sample_0;
      logic signed [SMP_W-1:0]  out_sample_1;
      logic signed [SMP_W-1:0]  out_sample_2;
      logic signed [SMP_W-1:0]  out_sample_3;
      logic [HELD_W-1:0]        routes_held;
      logic                     add_dropped;
   } rsp_word_type;

   typedef struct packed {
      logic [CH_W-1:0]          src;
      logic [CH_W-1:0]          dst;
      logic signed [SMP_W-1:0]  gain;
   } route_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ hw/rtl/audio_route_matrix_mixer.sv @@
// Audio route matrix mixer: route chain, command sequencer and result register.
// Add and clear: the command goes straight to the emit state and the result register. Remove:
// the chain compacts one slot or steps one slot per cycle.
// Mix: the route chain makes a full rotation, one cell per cycle, past
// a single multiply-accumulate unit. One word is worked on at a time.
// Synchronous reset empties the route table and sets both active counts to 4.
`default_nettype none

module audio_route_matrix_mixer #(
   parameter int MAX_ROUTES   = armm_pkg::MAX_ROUTES_DEF,
   parameter int NUM_CHANNELS = armm_pkg::NUM_CH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire armm_pkg::req_word_type             req_word,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output armm_pkg::rsp_word_type                  rsp_word,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [armm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [armm_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int IDX_W    = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
   localparam int CNT_W    = $clog2(MAX_ROUTES + 1);
   localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int ACC_W    = armm_pkg::PROD_W + 1 + $clog2(MAX_ROUTES + 1);
   localparam int SW       = armm_pkg::SMP_W;
   localparam int HW       = armm_pkg::HELD_W;
   localparam int CW       = armm_pkg::CMP_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REMOVE,
      S_MIX,
      S_DRAIN,
      S_EMIT
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           total_ff, total_in;
   logic [CNT_W-1:0]           p_ff, p_in;
   logic [IDX_W-1:0]           k_ff, k_in;
   logic                       drain_ff, drain_in;
   logic [armm_pkg::CH_W-1:0]  key_src_ff, key_src_in;
   logic [armm_pkg::CH_W-1:0]  key_dst_ff, key_dst_in;
   armm_pkg::rsp_word_type     res_ff, res_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   armm_pkg::rsp_word_type     rsp_word_ff, rsp_word_in;
   logic [armm_pkg::CFG_W-1:0] act_in_ff, act_out_ff;

   logic                       add_load, mix_shift, rem_shift, mac_clear, mac_step;
   logic                       smp_load, step_ok;
   logic signed [SW-1:0]       req_smp [armm_pkg::OUT_CH];
   logic signed [SW-1:0]       smp_ff  [NUM_CHANNELS];
   logic signed [SW-1:0]       mixed   [armm_pkg::OUT_CH];
   logic signed [SW-1:0]       head_smp;

   armm_pkg::route_type        route_q  [MAX_ROUTES];
   armm_pkg::cell_ctl_type     cell_ctl [MAX_ROUTES];
   logic [MAX_ROUTES-1:0]      match_vec;
   armm_pkg::route_type        new_route;

   // ---------------- route chain ----------------
   assign new_route.src  = req_word.src_channel;
   assign new_route.dst  = req_word.dst_channel;
   assign new_route.gain = req_word.route_gain;

   for (genvar i = 0; i < MAX_ROUTES; i++) begin : g_cell
      localparam logic [CNT_W-1:0] CELL_IDX = CNT_W'(i);
      assign cell_ctl[i].load  = add_load && (total_ff == CELL_IDX);
      assign cell_ctl[i].shift = mix_shift || (rem_shift && (CELL_IDX >= p_ff));
      armm_route_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .load_route (new_route),
         .next_route (route_q[(i + 1) % MAX_ROUTES]),
         .key_src    (key_src_ff),
         .key_dst    (key_dst_ff),
         .route      (route_q[i]),
         .match      (match_vec[i])
      );
   end

   // ---------------- samples and MAC ----------------
   assign req_smp[0] = req_word.in_sample_0;
   assign req_smp[1] = req_word.in_sample_1;
   assign req_smp[2] = req_word.in_sample_2;
   assign req_smp[3] = req_word.in_sample_3;

   for (genvar j = 0; j < NUM_CHANNELS; j++) begin : g_smp
      always_ff @(posedge clock) begin
         if (smp_load) begin
            smp_ff[j] <= (j < armm_pkg::OUT_CH) ? req_smp[j % armm_pkg::OUT_CH] : '0;
         end
      end
   end

   // route counts only if both ends are below the active and built channel counts
   assign step_ok = (CW'(route_q[0].src) < CW'(act_in_ff))
                 && (CW'(route_q[0].src) < CW'(NUM_CHANNELS))
                 && (CW'(route_q[0].dst) < CW'(act_out_ff))
                 && (CW'(route_q[0].dst) < CW'(NUM_CHANNELS));
   assign head_smp = step_ok ? smp_ff[route_q[0].src[CH_IDX_W-1:0]] : '0;

   armm_mac #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .ACC_W        (ACC_W)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .clear  (mac_clear),
      .step   (mac_step),
      .gain   (route_q[0].gain),
      .sample (head_smp),
      .dst    (route_q[0].dst),
      .mixed  (mixed)
   );

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_in_ff  <= armm_pkg::ACT_RESET;
         act_out_ff <= armm_pkg::ACT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            armm_pkg::CSR_ACTIVE_INPUTS:  act_in_ff  <= csr_wdata;
            armm_pkg::CSR_ACTIVE_OUTPUTS: act_out_ff <= csr_wdata;
         endcase
      end
   end

   // ---------------- sequencer ----------------
   assign req_stall = (state_ff != S_IDLE);
   assign smp_load  = (state_ff == S_IDLE) && req_valid && (req_word.cmd == armm_pkg::CMD_MIX);

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      p_in         = p_ff;
      k_in         = k_ff;
      drain_in     = drain_ff;
      key_src_in   = key_src_ff;
      key_dst_in   = key_dst_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      add_load     = 1'b0;
      mix_shift    = 1'b0;
      rem_shift    = 1'b0;
      mac_clear    = 1'b0;
      mac_step     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in     = '0;
               key_src_in = req_word.src_channel;
               key_dst_in = req_word.dst_channel;
               unique case (req_word.cmd)
                  armm_pkg::CMD_ADD: begin
                     if (total_ff < CNT_W'(MAX_ROUTES)) begin
                        add_load = 1'b1;
                        total_in = total_ff + 1'b1;
                     end else begin
                        res_in.add_dropped = 1'b1;
                     end
                     res_in.routes_held = HW'(total_in);
                     state_in = S_EMIT;
                  end
                  armm_pkg::CMD_REMOVE: begin
                     p_in     = '0;
                     state_in = S_REMOVE;
                  end
                  armm_pkg::CMD_CLEAR: begin
                     total_in = '0;
                     state_in = S_EMIT;
                  end
                  armm_pkg::CMD_MIX: begin
                     mac_clear = 1'b1;
                     k_in      = '0;
                     state_in  = S_MIX;
                  end
               endcase
            end
         end
         S_REMOVE: begin
            if (p_ff == total_ff) begin
               res_in.routes_held = HW'(total_ff);
               state_in = S_EMIT;
            end else if (match_vec[p_ff[IDX_W-1:0]]) begin
               // drop slot p: everything from p upward moves down one
               rem_shift = 1'b1;
               total_in  = total_ff - 1'b1;
            end else begin
               p_in = p_ff + 1'b1;
            end
         end
         S_MIX: begin
            // full rotation: the chain ends where it started
            mix_shift = 1'b1;
            mac_step  = (CNT_W'(k_ff) < total_ff) && step_ok;
            k_in      = k_ff + 1'b1;
            if (k_ff == IDX_W'(MAX_ROUTES - 1)) begin
               drain_in = 1'b0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               res_in.out_sample_0 = mixed[0];
               res_in.out_sample_1 = mixed[1];
               res_in.out_sample_2 = mixed[2];
               res_in.out_sample_3 = mixed[3];
               res_in.routes_held  = HW'(total_ff);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         drain_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         drain_ff     <= drain_in;
      end
      p_ff        <= p_in;
      k_ff        <= k_in;
      key_src_ff  <= key_src_in;
      key_dst_ff  <= key_dst_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------- checks ----------------
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(MAX_ROUTES))
      else $error("route count above table size");

   a_remove_no_grow: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REMOVE |=> total_ff <= $past(total_ff))
      else $error("route count grew during remove");

   a_mix_stable: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MIX |=> $stable(total_ff))
      else $error("route count changed during mix");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result word raised outside emit");

endmodule

`default_nettype wire

@@ hw/rtl/armm_route_cell.sv @@
// One slot of the route chain: holds a route, loads or takes its neighbour's.
`default_nettype none

module armm_route_cell (
   input  wire logic                      clock,
   input  wire armm_pkg::cell_ctl_type    ctl,
   input  wire armm_pkg::route_type       load_route,
   input  wire armm_pkg::route_type       next_route,
   input  wire logic [armm_pkg::CH_W-1:0] key_src,
   input  wire logic [armm_pkg::CH_W-1:0] key_dst,
   output armm_pkg::route_type            route,
   output logic                           match
);

   armm_pkg::route_type route_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         route_ff <= load_route;
      end else if (ctl.shift) begin
         route_ff <= next_route;
      end
   end

   assign route = route_ff;
   assign match = (route_ff.src == key_src) && (route_ff.dst == key_dst);

endmodule

`default_nettype wire

@@ hw/rtl/armm_mac.sv @@
// Gain multiply, per-channel accumulate and Q1.15 saturation.
`default_nettype none

module armm_mac #(
   parameter int NUM_CHANNELS = armm_pkg::NUM_CH_DEF,
   parameter int ACC_W        = 37
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              clear,
   input  wire logic                              step,
   input  wire logic signed [armm_pkg::SMP_W-1:0] gain,
   input  wire logic signed [armm_pkg::SMP_W-1:0] sample,
   input  wire logic [armm_pkg::CH_W-1:0]         dst,
   output logic signed [armm_pkg::SMP_W-1:0]      mixed [armm_pkg::OUT_CH]
);

   localparam int PW = armm_pkg::PROD_W;
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(armm_pkg::SMP_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(armm_pkg::SMP_MIN);

   logic                           v_ff;
   logic signed [PW-1:0]           prod_ff;
   logic [armm_pkg::CH_W-1:0]      dst_ff;
   logic signed [ACC_W-1:0]        acc_ff [NUM_CHANNELS];
   logic signed [PW-1:0]           prod_in;

   assign prod_in = gain * sample;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= step;
      end
      prod_ff <= prod_in;
      dst_ff  <= dst;
   end

   for (genvar j = 0; j < NUM_CHANNELS; j++) begin : g_acc
      localparam logic [armm_pkg::CH_W-1:0] CH = armm_pkg::CH_W'(j);
      always_ff @(posedge clock) begin
         if (clear) begin
            acc_ff[j] <= '0;
         end else if (v_ff && dst_ff == CH) begin
            acc_ff[j] <= acc_ff[j] + {{(ACC_W-PW){prod_ff[PW-1]}}, prod_ff};
         end
      end
   end

   for (genvar j = 0; j < armm_pkg::OUT_CH; j++) begin : g_sat
      if (j < NUM_CHANNELS) begin : g_live
         logic signed [ACC_W-1:0] sh;
         assign sh = acc_ff[j] >>> armm_pkg::FRAC_W;
         always_comb begin
            if (sh > SAT_HI) begin
               mixed[j] = armm_pkg::SMP_MAX;
            end else if (sh < SAT_LO) begin
               mixed[j] = armm_pkg::SMP_MIN;
            end else begin
               mixed[j] = sh[armm_pkg::SMP_W-1:0];
            end
         end
      end else begin : g_none
         assign mixed[j] = '0;
      end
   end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the audio route matrix mixer: route table tracker and drivers.
`timescale 1ns / 1ps

module testbench;

   localparam int ROUTE_SLOTS = armm_pkg::MAX_ROUTES_DEF;
   localparam int CHANNELS    = armm_pkg::NUM_CH_DEF;
   localparam int MIX_CYCLES  = ROUTE_SLOTS + 4;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 4000;
   localparam int CHUNK_ITEMS = 50;
   localparam int CHUNKS      = 9;

   // Tracks the route table and active counts, and queues the output words they imply.
   class route_table_board;
      logic [armm_pkg::CH_W-1:0]         src_tab[ROUTE_SLOTS];
      logic [armm_pkg::CH_W-1:0]         dst_tab[ROUTE_SLOTS];
      logic signed [armm_pkg::SMP_W-1:0] gain_tab[ROUTE_SLOTS];
      int unsigned                       route_count;
      logic [armm_pkg::CFG_W-1:0]        live_inputs;
      logic [armm_pkg::CFG_W-1:0]        live_outputs;
      armm_pkg::rsp_word_type            pending_outputs[$];
      int                                failures;

      function new();
         route_count  = 0;
         live_inputs  = armm_pkg::ACT_RESET;
         live_outputs = armm_pkg::ACT_RESET;
         failures     = 0;
      endfunction

      function armm_pkg::rsp_word_type apply_command(armm_pkg::req_word_type w);
         armm_pkg::rsp_word_type            o;
         logic signed [armm_pkg::SMP_W-1:0] smp[armm_pkg::OUT_CH];
         logic signed [armm_pkg::SMP_W-1:0] sat[armm_pkg::OUT_CH];
         longint                            acc[armm_pkg::OUT_CH];
         longint                            q;
         int unsigned                       keep, ni, no;
         o = '0;
         case (w.cmd)
            armm_pkg::CMD_ADD: begin
               if (route_count >= ROUTE_SLOTS) begin
                  o.add_dropped = 1'b1;
               end else begin
                  src_tab[route_count]  = w.src_channel;
                  dst_tab[route_count]  = w.dst_channel;
                  gain_tab[route_count] = w.route_gain;
                  route_count++;
               end
            end
            armm_pkg::CMD_REMOVE: begin
               // survivors close up in order
               keep = 0;
               for (int r = 0; r < route_count; r++) begin
                  if (!(src_tab[r] == w.src_channel && dst_tab[r] == w.dst_channel)) begin
                     src_tab[keep]  = src_tab[r];
                     dst_tab[keep]  = dst_tab[r];
                     gain_tab[keep] = gain_tab[r];
                     keep++;
                  end
               end
               route_count = keep;
            end
            armm_pkg::CMD_CLEAR: begin
               route_count = 0;
            end
            armm_pkg::CMD_MIX: begin
               smp[0] = w.in_sample_0;
               smp[1] = w.in_sample_1;
               smp[2] = w.in_sample_2;
               smp[3] = w.in_sample_3;
               ni = (live_inputs > CHANNELS) ? CHANNELS : live_inputs;
               no = (live_outputs > CHANNELS) ? CHANNELS : live_outputs;
               for (int j = 0; j < armm_pkg::OUT_CH; j++) acc[j] = 0;
               for (int r = 0; r < route_count; r++) begin
                  if (src_tab[r] < ni && dst_tab[r] < no)
                     acc[dst_tab[r]] += longint'(gain_tab[r]) * longint'(smp[src_tab[r]]);
               end
               // Q5.27 down to Q1.15, floor then clamp
               for (int j = 0; j < armm_pkg::OUT_CH; j++) begin
                  q = acc[j] >>> armm_pkg::FRAC_W;
                  if (q > 32767) q = 32767;
                  if (q < -32768) q = -32768;
                  sat[j] = armm_pkg::SMP_W'(q);
               end
               o.out_sample_0 = sat[0];
               o.out_sample_1 = sat[1];
               o.out_sample_2 = sat[2];
               o.out_sample_3 = sat[3];
            end
         endcase
         o.routes_held = armm_pkg::HELD_W'(route_count);
         return o;
      endfunction

      task take_command(armm_pkg::req_word_type w);
         pending_outputs.push_back(apply_command(w));
      endtask

      task report(string what, longint got, longint want);
         failures++;
         $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      endtask

      task match_output(armm_pkg::rsp_word_type got);
         armm_pkg::rsp_word_type want;
         if (pending_outputs.size() == 0) begin
            report("output word with none outstanding", got.routes_held, 0);
            return;
         end
         want = pending_outputs.pop_front();
         if (got.out_sample_0 !== want.out_sample_0)
            report("out_sample_0", got.out_sample_0, want.out_sample_0);
         if (got.out_sample_1 !== want.out_sample_1)
            report("out_sample_1", got.out_sample_1, want.out_sample_1);
         if (got.out_sample_2 !== want.out_sample_2)
            report("out_sample_2", got.out_sample_2, want.out_sample_2);
         if (got.out_sample_3 !== want.out_sample_3)
            report("out_sample_3", got.out_sample_3, want.out_sample_3);
         if (got.routes_held !== want.routes_held)
            report("routes_held", got.routes_held, want.routes_held);
         if (got.add_dropped !== want.add_dropped)
            report("add_dropped", got.add_dropped, want.add_dropped);
      endtask
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   armm_pkg::req_word_type         req_word;
   logic                           rsp_valid;
   logic                           rsp_stall;
   armm_pkg::rsp_word_type         rsp_word;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [armm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [armm_pkg::CFG_W-1:0]     csr_wdata;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_asked    = 0;
   int hold_done     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   route_table_board board;

   audio_route_matrix_mixer dut (.*);

   always #1 clock = ~clock;

   function automatic armm_pkg::req_word_type route_word(armm_pkg::cmd_type c, int s, int d,
                                               logic signed [armm_pkg::SMP_W-1:0] g);
      armm_pkg::req_word_type w;
      w             = '0;
      w.cmd         = c;
      w.src_channel = armm_pkg::CH_W'(s);
      w.dst_channel = armm_pkg::CH_W'(d);
      w.route_gain  = g;
      return w;
   endfunction

   function automatic armm_pkg::req_word_type mix_word(logic signed [armm_pkg::SMP_W-1:0] s0,
                                             logic signed [armm_pkg::SMP_W-1:0] s1,
                                             logic signed [armm_pkg::SMP_W-1:0] s2,
                                             logic signed [armm_pkg::SMP_W-1:0] s3);
      armm_pkg::req_word_type w;
      w             = '0;
      w.cmd         = armm_pkg::CMD_MIX;
      w.in_sample_0 = s0;
      w.in_sample_1 = s1;
      w.in_sample_2 = s2;
      w.in_sample_3 = s3;
      return w;
   endfunction

   function automatic logic [armm_pkg::CH_W-1:0] pick_channel();
      if ($urandom_range(0, 99) < 80) return armm_pkg::CH_W'($urandom_range(0, CHANNELS));
      return armm_pkg::CH_W'($urandom_range(0, 15));
   endfunction

   function automatic logic signed [armm_pkg::SMP_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return armm_pkg::SMP_MAX;
         1: return armm_pkg::SMP_MIN;
         2: return '0;
         3: return armm_pkg::SMP_W'(int'($urandom_range(0, 8192)) - 4096);
         default: return armm_pkg::SMP_W'($urandom);
      endcase
   endfunction

   function automatic armm_pkg::req_word_type random_command();
      armm_pkg::req_word_type w;
      int unsigned            pick, r;
      w.src_channel = pick_channel();
      w.dst_channel = pick_channel();
      w.route_gain  = pick_value();
      w.in_sample_0 = pick_value();
      w.in_sample_1 = pick_value();
      w.in_sample_2 = pick_value();
      w.in_sample_3 = pick_value();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         w.cmd = armm_pkg::CMD_ADD;
      end else if (pick < 55) begin
         w.cmd = armm_pkg::CMD_REMOVE;
         // mostly aim at a route that is actually held
         if (board.route_count > 0 && $urandom_range(0, 3) != 0) begin
            r = $urandom_range(0, board.route_count - 1);
            w.src_channel = board.src_tab[r];
            w.dst_channel = board.dst_tab[r];
         end
      end else if (pick < 61) begin
         w.cmd = armm_pkg::CMD_CLEAR;
      end else begin
         w.cmd = armm_pkg::CMD_MIX;
      end
      return w;
   endfunction

   task automatic send_word(armm_pkg::req_word_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      board.take_command(w);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending_outputs.size() != 0);
   endtask

   task automatic write_settings(logic [armm_pkg::CFG_W-1:0] ins,
                                 logic [armm_pkg::CFG_W-1:0] outs);
      drain_results();
      repeat (MIX_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= armm_pkg::CSR_ACTIVE_INPUTS;
      csr_wdata <= ins;
      do @(posedge clock); while (!csr_ready);
      board.live_inputs = ins;
      csr_index <= armm_pkg::CSR_ACTIVE_OUTPUTS;
      csr_wdata <= outs;
      do @(posedge clock); while (!csr_ready);
      board.live_outputs = outs;
      csr_valid <= 1'b0;
   endtask

   // output side: check, then choose next cycle's stall
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) board.match_output(rsp_word);
      if (hold_asked != hold_done) begin
         hold_done = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [armm_pkg::CFG_W-1:0] ins, outs;
      board     = new();
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = armm_pkg::CSR_ACTIVE_INPUTS;
      csr_wdata = armm_pkg::ACT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 17;
      recv_idle_pct = 60;
      // empty table
      send_word(mix_word(armm_pkg::SMP_MAX, armm_pkg::SMP_MIN,
                         armm_pkg::SMP_MAX, armm_pkg::SMP_MIN));
      send_word(route_word(armm_pkg::CMD_ADD, 0, 0, armm_pkg::SMP_MAX));
      send_word(route_word(armm_pkg::CMD_ADD, 2, 1, armm_pkg::SMP_MIN));
      // both clip high
      send_word(mix_word(armm_pkg::SMP_MAX, 16'sh0001, armm_pkg::SMP_MIN, 16'shFFFF));
      // both clip low
      send_word(mix_word(armm_pkg::SMP_MIN, 16'sh0001, armm_pkg::SMP_MAX, 16'shFFFF));
      // held, never mixed
      send_word(route_word(armm_pkg::CMD_ADD, 15, 15, 16'sh1000));
      // duplicate
      send_word(route_word(armm_pkg::CMD_ADD, 0, 0, 16'sh0800));
      // drops both copies
      send_word(route_word(armm_pkg::CMD_REMOVE, 0, 0, 16'sh7FFF));
      // no match
      send_word(route_word(armm_pkg::CMD_REMOVE, 9, 9, armm_pkg::SMP_MIN));
      send_word(mix_word(16'sh4000, 16'sh1234, armm_pkg::SMP_MAX, 16'shC000));
      for (int i = 0; i < 14; i++)
         send_word(route_word(armm_pkg::CMD_ADD, i % 5, (i * 3) % 5,
                              armm_pkg::SMP_W'(i * 2345 - 16000)));
      // table full
      send_word(route_word(armm_pkg::CMD_ADD, 3, 3, armm_pkg::SMP_MAX));
      send_word(mix_word(16'sh2000, armm_pkg::SMP_MIN, 16'sh7000, armm_pkg::SMP_MAX));
      send_word(route_word(armm_pkg::CMD_CLEAR, 15, 15, armm_pkg::SMP_MIN));

      for (int k = 0; k < CHUNKS; k++) begin
         case (k)
            0: begin ins = 3'd0; outs = 3'd4; end
            1: begin ins = 3'd4; outs = 3'd0; end
            2: begin ins = 3'd7; outs = 3'd7; end
            3: begin ins = 3'd1; outs = 3'd3; end
            4: begin ins = 3'd3; outs = 3'd1; end
            5: begin ins = 3'd5; outs = 3'd6; end
            6: begin ins = 3'd2; outs = 3'd2; end
            7: begin ins = 3'd4; outs = 3'd4; end
            default: begin
               ins  = armm_pkg::CFG_W'($urandom_range(0, 7));
               outs = armm_pkg::CFG_W'($urandom_range(0, 7));
            end
         endcase
         write_settings(ins, outs);
         send_idle_pct = (k < 3) ? 17 : (k < 6) ? 60 : 0;
         recv_idle_pct = (k < 3) ? 60 : (k < 6) ? 17 : 0;
         for (int n = 0; n < CHUNK_ITEMS; n++) begin
            // long output hold so the block backs up onto its input
            if (k == 1 && n == 20) hold_asked <= hold_asked + 1;
            if (k == 7 && n == 25) drain_results();
            send_word(random_command());
         end
      end

      drain_results();
      repeat (MIX_CYCLES + 10) @(posedge clock);
      if (board.failures == 0 && board.pending_outputs.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/armm_pkg.sv
hw/rtl/armm_route_cell.sv
hw/rtl/armm_mac.sv
hw/rtl/audio_route_matrix_mixer.sv
dv/testbench.sv
